>>> design/ewfs_pkg.sv
`default_nettype none
package ewfs_pkg;

	localparam int MAX_WORKERS = 64;
	localparam int IDX_W       = $clog2(MAX_WORKERS);
	localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
	localparam int CHILD_W     = IDX_W + 2;
	localparam int WORKER_W    = 6;
	localparam int TIME_W      = 63;
	localparam int DUR_W       = 32;
	localparam int CFG_W       = 7;

	typedef struct packed {
		logic [WORKER_W-1:0] worker;
		logic [TIME_W-1:0]   ftime;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_EMIT,
		ST_RD,
		ST_CMP
	} state_t;

	// A slot never written since the last clear holds its own worker at time zero.
	function automatic entry_t fix_entry(entry_t e, logic v, logic [IDX_W-1:0] idx);
		entry_t r;
		r = e;
		if (!v) begin
			r.worker = WORKER_W'(idx);
			r.ftime  = '0;
		end
		return r;
	endfunction

	function automatic logic key_less(entry_t a, entry_t b);
		logic r;
		if (a.ftime != b.ftime) begin
			r = a.ftime < b.ftime;
		end else begin
			r = a.worker < b.worker;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/ewfs_ifs.sv
`default_nettype none
interface ewfs_job_if import ewfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DUR_W-1:0] job_duration;
	modport source (output valid, output job_duration, input ready);
	modport sink   (input valid, input job_duration, output ready);
endinterface

interface ewfs_res_if import ewfs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORKER_W-1:0] worker_index;
	logic [TIME_W-1:0]   start_time;
	modport source (output valid, output worker_index, output start_time, input ready);
	modport sink   (input valid, input worker_index, input start_time, output ready);
endinterface

interface ewfs_cfg_if import ewfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] active_workers;
	modport source (output valid, output active_workers, input ready);
	modport sink   (input valid, input active_workers, output ready);
endinterface
`default_nettype wire

>>> design/earliest_free_worker_scheduler_core.sv
`default_nettype none
// Earliest-free worker scheduler.
// job_in carries one job duration per transaction; res_out returns, for each
// job, the worker it is assigned to and the tick at which it starts there.
// cfg writes active_workers (0 is taken as 1, values above the worker limit
// as the limit); a write puts every worker back to free time zero. cfg.ready
// is always high; write it only while no job is in flight.
// The heap of (free time, worker) keys lives in one RAM with one write port,
// two read ports and a registered read. Per job the core steps through IDLE
// (accept), ROOT (read the root) and EMIT (emit the result and saturate the
// new free time), then RD (read both children) and CMP (compare and write
// back) for every level that gets compared; an entry that ends in a slot with
// no child is written back in RD. With 64 workers the entry moves down at most
// 6 levels. The result register is loaded when EMIT is left, and the next job
// is taken once sift-down is done.
// The result sits in an output register; if the receiver stalls, the next
// job is still accepted, and its emit step waits until that register frees.
// Reset makes all workers active and all free times zero; per-slot valid
// flops stand in for the RAM contents, so no clearing pass is needed.
module earliest_free_worker_scheduler_core import ewfs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ewfs_job_if.sink   job_in,
	ewfs_res_if.source res_out,
	ewfs_cfg_if.sink   cfg
);
	state_t state_q, state_d;

	logic [CNT_W-1:0]   nwork_q;
	logic               slot_vld_q [MAX_WORKERS];
	logic [DUR_W-1:0]   dur_q;
	entry_t             cur_q;
	logic [IDX_W-1:0]   cur_idx_q;
	logic [CHILD_W-1:0] left_q;
	logic               res_vld_q;
	logic [WORKER_W-1:0] res_worker_q;
	logic [TIME_W-1:0]   res_time_q;

	// ram ports
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic [IDX_W-1:0] raddr_a, raddr_b;
	logic [ENTRY_W-1:0] rdata_a, rdata_b;

	logic [CHILD_W-1:0] left_c, right_c, right_q;
	logic               left_ok, right_ok;
	entry_t             root_e, l_e, r_e, best_e;
	logic [IDX_W-1:0]   best_idx;
	logic               swap;
	logic               emit_go;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  new_time;

	assign left_c   = {1'b0, cur_idx_q, 1'b1};
	assign right_q  = left_q + CHILD_W'(1);
	assign left_ok  = left_c < CHILD_W'(nwork_q);
	assign right_ok = right_q < CHILD_W'(nwork_q);

	assign root_e = fix_entry(entry_t'(rdata_a), slot_vld_q[0], '0);
	assign l_e    = fix_entry(entry_t'(rdata_a), slot_vld_q[left_q[IDX_W-1:0]],
		left_q[IDX_W-1:0]);
	assign r_e    = fix_entry(entry_t'(rdata_b), slot_vld_q[right_q[IDX_W-1:0]],
		right_q[IDX_W-1:0]);

	always_comb begin
		if (right_ok && key_less(r_e, l_e)) begin
			best_e   = r_e;
			best_idx = right_q[IDX_W-1:0];
		end else begin
			best_e   = l_e;
			best_idx = left_q[IDX_W-1:0];
		end
	end
	assign swap = key_less(best_e, cur_q);

	// saturate the new free time at its maximum
	assign sum      = {1'b0, root_e.ftime} + (TIME_W + 1)'(dur_q);
	assign new_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	assign emit_go = !res_vld_q || res_out.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (job_in.valid) state_d = ST_ROOT;
			ST_ROOT: state_d = ST_EMIT;
			ST_EMIT: if (emit_go) state_d = ST_RD;
			ST_RD:   state_d = left_ok ? ST_CMP : ST_IDLE;
			ST_CMP:  state_d = swap ? ST_RD : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		we      = 1'b0;
		waddr   = cur_idx_q;
		wdata   = cur_q;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			ST_RD: begin
				raddr_a = left_c[IDX_W-1:0];
				raddr_b = right_c[IDX_W-1:0];
				we      = !left_ok;
			end
			ST_CMP: begin
				we = 1'b1;
				if (swap) wdata = best_e;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end
	assign right_c = left_c + CHILD_W'(1);

	ewfs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_WORKERS)
	) u_heap_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			nwork_q   <= CNT_W'(MAX_WORKERS);
			res_vld_q <= 1'b0;
			for (int i = 0; i < MAX_WORKERS; i++) slot_vld_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			// load a new result, or drop the old one once the receiver takes it
			if (state_q == ST_EMIT && emit_go) begin
				res_vld_q <= 1'b1;
			end else if (res_out.ready) begin
				res_vld_q <= 1'b0;
			end
			if (cfg.valid) begin
				if (cfg.active_workers == '0) begin
					nwork_q <= CNT_W'(1);
				end else if (int'(cfg.active_workers) > MAX_WORKERS) begin
					nwork_q <= CNT_W'(MAX_WORKERS);
				end else begin
					nwork_q <= CNT_W'(cfg.active_workers);
				end
				for (int i = 0; i < MAX_WORKERS; i++) slot_vld_q[i] <= 1'b0;
			end else if (we) begin
				slot_vld_q[waddr] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_in.valid) dur_q <= job_in.job_duration;
		if (state_q == ST_EMIT && emit_go) begin
			res_worker_q <= root_e.worker;
			res_time_q   <= root_e.ftime;
			cur_q.worker <= root_e.worker;
			cur_q.ftime  <= new_time;
			cur_idx_q    <= '0;
		end
		if (state_q == ST_RD) left_q <= left_c;
		if (state_q == ST_CMP && swap) cur_idx_q <= best_idx;
	end

	assign job_in.ready         = (state_q == ST_IDLE);
	assign cfg.ready            = 1'b1;
	assign res_out.valid        = res_vld_q;
	assign res_out.worker_index = res_worker_q;
	assign res_out.start_time   = res_time_q;
endmodule
`default_nettype wire

>>> design/ewfs_ram.sv
`default_nettype none
module ewfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule
`default_nettype wire

>>> design/ewfs_checker.sv
`default_nettype none
module ewfs_checker import ewfs_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                job_valid,
	input wire logic                job_ready,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic [WORKER_W-1:0] res_worker,
	input wire logic [TIME_W-1:0]   res_time
);
	logic job_acc;
	assign job_acc = job_valid && job_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_worker) && $stable(res_time))
		else $error("result payload changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_acc |=> !job_ready)
		else $error("job taken during sift-down");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		job_acc |=> !$rose(res_valid))
		else $error("result too early");
endmodule

bind earliest_free_worker_scheduler_core ewfs_checker u_ewfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.job_valid (job_in.valid),
	.job_ready (job_in.ready),
	.res_valid (res_out.valid),
	.res_ready (res_out.ready),
	.res_worker(res_out.worker_index),
	.res_time  (res_out.start_time)
);
`default_nettype wire

>>> bench/ewfs_sched_checker.sv
`default_nettype none
module ewfs_sched_checker import ewfs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ewfs_job_if.sink   job_mon,
	ewfs_res_if.sink   res_mon,
	ewfs_cfg_if.sink   cfg_mon,
	output int         fail_count,
	output int         pending
);

	localparam logic [TIME_W-1:0] TIME_TOP = '1;

	typedef struct packed {
		logic [WORKER_W-1:0] worker;
		logic [TIME_W-1:0]   start;
	} assign_t;

	int                  n_active;
	logic [WORKER_W-1:0] pool_worker [MAX_WORKERS];
	logic [TIME_W-1:0]   pool_free   [MAX_WORKERS];
	assign_t             assign_q [$];

	function automatic bit earlier(int a, int b);
		if (pool_free[a] != pool_free[b]) begin
			return pool_free[a] < pool_free[b];
		end
		return pool_worker[a] < pool_worker[b];
	endfunction

	task automatic clear_pool(input logic [CFG_W-1:0] count);
		int v;
		v = int'(count);
		if (v == 0) begin
			v = 1;
		end
		if (v > MAX_WORKERS) begin
			v = MAX_WORKERS;
		end
		n_active = v;
		for (int i = 0; i < MAX_WORKERS; i++) begin
			pool_worker[i] = WORKER_W'(i);
			pool_free[i]   = '0;
		end
	endtask

	task automatic dispatch_job(input logic [DUR_W-1:0] dur);
		assign_t             a;
		logic [TIME_W:0]     sum;
		int                  cur;
		int                  l;
		int                  best;
		logic [WORKER_W-1:0] tw;
		logic [TIME_W-1:0]   tt;
		a.worker = pool_worker[0];
		a.start  = pool_free[0];
		assign_q = {assign_q, a};
		sum = {1'b0, pool_free[0]} + (TIME_W + 1)'(dur);
		pool_free[0] = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
		cur = 0;
		forever begin
			l = 2 * cur + 1;
			if (l >= n_active) begin
				break;
			end
			best = l;
			if (l + 1 < n_active && earlier(l + 1, l)) begin
				best = l + 1;
			end
			if (!earlier(best, cur)) begin
				break;
			end
			tw = pool_worker[best];
			tt = pool_free[best];
			pool_worker[best] = pool_worker[cur];
			pool_free[best]   = pool_free[cur];
			pool_worker[cur]  = tw;
			pool_free[cur]    = tt;
			cur = best;
		end
	endtask

	assign pending = assign_q.size();

	always @(posedge clk or negedge arst_n) begin
		assign_t a;
		if (!arst_n) begin
			fail_count <= 0;
			assign_q.delete();
			clear_pool(CFG_W'(MAX_WORKERS));
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				clear_pool(cfg_mon.active_workers);
			end
			if (job_mon.valid && job_mon.ready) begin
				dispatch_job(job_mon.job_duration);
			end
			if (res_mon.valid && res_mon.ready) begin
				if (assign_q.size() == 0) begin
					$display("%0t: unexpected result worker %0d start %0d", $time,
						res_mon.worker_index, res_mon.start_time);
					fail_count <= fail_count + 1;
				end else begin
					a = assign_q.pop_front();
					if (a.worker !== res_mon.worker_index || a.start !== res_mon.start_time) begin
						$display("%0t: mismatch expected worker %0d start %0d, got %0d start %0d",
							$time, a.worker, a.start, res_mon.worker_index, res_mon.start_time);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> bench/tb_earliest_free_worker_scheduler_core.sv
`default_nettype none
module tb_earliest_free_worker_scheduler_core;
	import ewfs_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   sink_hold;   // receiver held off for a forced stall
	bit   stall_go;    // start the forced stall
	bit   calm_send;   // no random gaps on the job side
	bit   calm_recv;   // no random gaps on the result side
	bit   jobs_done;
	logic [CFG_W-1:0] counts [7] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd3, 7'd65};

	ewfs_job_if job_ch ();
	ewfs_res_if res_ch ();
	ewfs_cfg_if cfg_ch ();

	earliest_free_worker_scheduler_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_in  (job_ch.sink),
		.res_out (res_ch.source),
		.cfg     (cfg_ch.sink)
	);

	ewfs_sched_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_mon    (job_ch.sink),
		.res_mon    (res_ch.sink),
		.cfg_mon    (cfg_ch.sink),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Forced stall: once requested, hold the receiver off, then release it.
	initial begin
		sink_hold = 1'b0;
		wait (stall_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (300) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// Receiver: random back-pressure, or held off during the forced stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (sink_hold) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= calm_recv || ($urandom_range(99) >= 20);
		end
	end

	// Offer one job and wait for the transaction; valid stays up for the next
	// job and drops only in a gap.
	task automatic send_job(input logic [DUR_W-1:0] dur);
		while (!calm_send && $urandom_range(99) < 20) begin
			job_ch.valid <= 1'b0;
			@(posedge clk);
		end
		job_ch.valid        <= 1'b1;
		job_ch.job_duration <= dur;
		do begin
			@(posedge clk);
		end while (!job_ch.ready);
	endtask

	// Drain all results, let the tail of sift-down finish, then write the count.
	task automatic set_workers(input logic [CFG_W-1:0] count);
		job_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.active_workers <= count;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [DUR_W-1:0] pick_duration();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return DUR_W'($urandom_range(3));
			3: return DUR_W'($urandom_range(1000));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		arst_n       = 1'b0;
		stall_go     = 1'b0;
		calm_send    = 1'b0;
		calm_recv    = 1'b0;
		jobs_done    = 1'b0;
		job_ch.valid = 1'b0;
		job_ch.job_duration = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.active_workers = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset count, zero and full durations, ties across all workers.
		send_job('0);
		send_job('1);
		send_job(32'd1);
		send_job(32'h8000_0000);
		send_job(32'h5555_5555);
		send_job(32'hAAAA_AAAA);
		send_job('0);
		send_job(32'd7);
		// Single worker: drive free time toward saturation with maximal durations.
		set_workers(7'd1);
		repeat (8) send_job('1);
		// Zero count is taken as one, too-large as the limit.
		set_workers(7'd0);
		send_job(32'd5);
		send_job(32'd5);
		set_workers(7'd127);
		send_job(32'd3);
		send_job('0);

		// Random phases over several counts; one phase without any gaps.
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 7) begin
				set_workers(counts[ph]);
			end else begin
				set_workers(CFG_W'($urandom_range(1, 64)));
			end
			calm_send = (ph == 4);
			calm_recv = (ph == 4);
			for (int n = 0; n < 75; n++) begin
				if (ph == 2 && n == 10) begin
					stall_go = 1'b1;
				end
				send_job(pick_duration());
			end
		end
		job_ch.valid <= 1'b0;
		calm_send = 1'b0;
		calm_recv = 1'b0;
		jobs_done = 1'b1;
	end

	initial begin
		wait (jobs_done);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
